// ----- rtl/pi_controller_rate_limited_reference_top_defines.svh -----
// assertion macros shared by the checker of the rate-limited pi controller
`ifndef PI_CONTROLLER_RATE_LIMITED_REFERENCE_TOP_DEFINES_SVH
`define PI_CONTROLLER_RATE_LIMITED_REFERENCE_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define PIRL_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define PIRL_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/pirl_pkg.sv -----
// package with widths, register codes, reset values and config type
`timescale 1ns / 1ps

package pirl_pkg;

  localparam int DATA_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 12;

  localparam int GAIN_W = 16;
  localparam int LIM_W  = 15;
  localparam int INT_W  = LIM_W + 1;

  localparam int APB_DW = 32;
  localparam int APB_AW = 4;

  typedef enum logic [1:0] {
    REG_PROP_GAIN = 2'd0,
    REG_INT_GAIN  = 2'd1,
    REG_OUT_LIMIT = 2'd2,
    REG_STEP_MAX  = 2'd3
  } reg_idx_e;

  localparam logic [GAIN_W-1:0] PROP_GAIN_RST = 16'd10240;
  localparam logic [GAIN_W-1:0] INT_GAIN_RST  = 16'd985;
  localparam logic [LIM_W-1:0]  OUT_LIMIT_RST = 15'd3891;
  localparam logic [LIM_W-1:0]  STEP_MAX_RST  = 15'd123;

  typedef struct packed {
    logic [GAIN_W-1:0] prop_gain;
    logic [GAIN_W-1:0] integral_gain;
    logic [LIM_W-1:0]  output_limit;
    logic [LIM_W-1:0]  ref_step_max;
  } cfg_t;

endpackage

// ----- rtl/pirl_if.sv -----
// stream interfaces for the sample items and the result items
`timescale 1ns / 1ps

interface pirl_in_if import pirl_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] measured;
  logic signed [DATA_WIDTH-1:0] reference;

  modport source (output valid, output measured, output reference, input ready);
  modport sink (input valid, input measured, input reference, output ready);
endinterface

interface pirl_out_if import pirl_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] drive;
  logic signed [DATA_WIDTH-1:0] limited_reference;

  modport source (output valid, output drive, output limited_reference, input ready);
  modport sink (input valid, input drive, input limited_reference, output ready);
endinterface

// ----- rtl/pi_controller_rate_limited_reference_top.sv -----
// top level of the pi controller with slew-limited reference
`timescale 1ns / 1ps

// pi controller with a slew-limited setpoint, signed q3.12 by default. each
// item carries a measurement and a requested reference; the block moves its
// stored reference toward the request by at most ref_step_max, takes the
// error against the measurement, and returns the clamped proportional term
// plus the anti-windup integral as drive, together with the reference used.
// one item is accepted every cycle while the output is not stalled, and
// each item passes in order through the four register stages (input,
// slew and error, gain multipliers, clamp and integral). the reference
// state closes its loop inside the slew stage and the integral inside
// the last stage, so items follow back to back. a stalled output backs up
// stage by stage, and the input keeps taking items while any stage is
// free. registers sit on an apb port at byte addresses 0x0 prop_gain, 0x4
// integral_gain, 0x8 output_limit, 0xc ref_step_max and may be written
// only while no item is in flight. reset clears the state.
module pi_controller_rate_limited_reference_top import pirl_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  pirl_in_if.sink           in_i,
  pirl_out_if.source        out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int EW = DATA_WIDTH + 1;
  localparam int PW = DATA_WIDTH + GAIN_W + 2;

  cfg_t cfg;

  // stage valid bits
  logic v1_q, v2_q, v3_q, v4_q;
  // a stage can take an item when empty or when its item moves on
  logic adv1, adv2, adv3, adv4;
  logic t2, t3, t4;

  // stage 1: input register
  logic signed [DATA_WIDTH-1:0] meas1_q, ref1_q;
  // stage 2: error and slewed reference
  logic signed [EW-1:0]         err_d, err2_q;
  logic signed [DATA_WIDTH-1:0] lref_d, lref2_q;
  // stage 3: gain products
  logic signed [PW-1:0]         prop_prod3_q, int_prod3_q;
  logic signed [DATA_WIDTH-1:0] lref3_q;
  // stage 4: result register
  logic signed [DATA_WIDTH-1:0] drive_d, drive4_q, lref4_q;

  pirl_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // ready ripples back from the output through the free stages
  assign adv4 = !v4_q || out_o.ready;
  assign adv3 = !v3_q || adv4;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;

  assign in_i.ready = adv1;

  // item transfers into stages 2 to 4
  assign t2 = v1_q && adv2;
  assign t3 = v2_q && adv3;
  assign t4 = v3_q && adv4;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (adv1) begin
        v1_q <= in_i.valid;
      end
      if (adv2) begin
        v2_q <= v1_q;
      end
      if (adv3) begin
        v3_q <= v2_q;
      end
      if (adv4) begin
        v4_q <= v3_q;
      end
    end
  end

  // stage 1: capture the sample
  always_ff @(posedge clk_i) begin
    if (in_i.valid && adv1) begin
      meas1_q <= in_i.measured;
      ref1_q  <= in_i.reference;
    end
  end

  // stage 2: slew the reference, state advances with the item
  pirl_slew #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_slew (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_en_i   (t2),
    .measured_i  (meas1_q),
    .reference_i (ref1_q),
    .step_max_i  (cfg.ref_step_max),
    .err_o       (err_d),
    .lref_o      (lref_d)
  );

  always_ff @(posedge clk_i) begin
    if (t2) begin
      err2_q  <= err_d;
      lref2_q <= lref_d;
    end
  end

  // stage 3: both gain multiplies, gains are unsigned
  always_ff @(posedge clk_i) begin
    if (t3) begin
      prop_prod3_q <= PW'(err2_q) * PW'($signed({1'b0, cfg.prop_gain}));
      int_prod3_q  <= PW'(err2_q) * PW'($signed({1'b0, cfg.integral_gain}));
      lref3_q      <= lref2_q;
    end
  end

  // stage 4: clamps, integral update and drive sum
  pirl_integ #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_integ (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .upd_en_i    (t4),
    .prop_prod_i (prop_prod3_q),
    .int_prod_i  (int_prod3_q),
    .limit_i     (cfg.output_limit),
    .drive_o     (drive_d)
  );

  always_ff @(posedge clk_i) begin
    if (t4) begin
      drive4_q <= drive_d;
      lref4_q  <= lref3_q;
    end
  end

  assign out_o.valid             = v4_q;
  assign out_o.drive             = drive4_q;
  assign out_o.limited_reference = lref4_q;

endmodule

// ----- rtl/pirl_cfg.sv -----
// apb register file holding gains, output limit and reference step
`timescale 1ns / 1ps

module pirl_cfg import pirl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[APB_AW-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain     <= PROP_GAIN_RST;
      cfg_q.integral_gain <= INT_GAIN_RST;
      cfg_q.output_limit  <= OUT_LIMIT_RST;
      cfg_q.ref_step_max  <= STEP_MAX_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_PROP_GAIN: cfg_q.prop_gain     <= pwdata[GAIN_W-1:0];
        REG_INT_GAIN:  cfg_q.integral_gain <= pwdata[GAIN_W-1:0];
        REG_OUT_LIMIT: cfg_q.output_limit  <= pwdata[LIM_W-1:0];
        REG_STEP_MAX:  cfg_q.ref_step_max  <= pwdata[LIM_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_PROP_GAIN: prdata = APB_DW'(cfg_q.prop_gain);
      REG_INT_GAIN:  prdata = APB_DW'(cfg_q.integral_gain);
      REG_OUT_LIMIT: prdata = APB_DW'(cfg_q.output_limit);
      REG_STEP_MAX:  prdata = APB_DW'(cfg_q.ref_step_max);
    endcase
  end

endmodule

// ----- rtl/pirl_slew.sv -----
// slew limiter state for the reference and error against the measurement
`timescale 1ns / 1ps

module pirl_slew import pirl_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_en_i,
  input  logic signed [DATA_WIDTH-1:0] measured_i,
  input  logic signed [DATA_WIDTH-1:0] reference_i,
  input  logic        [LIM_W-1:0]      step_max_i,
  output logic signed [DATA_WIDTH:0]   err_o,
  output logic signed [DATA_WIDTH-1:0] lref_o
);

  localparam int EW = DATA_WIDTH + 1;
  localparam int XW = ((EW > LIM_W + 1) ? EW : LIM_W + 1) + 1;

  logic signed [DATA_WIDTH-1:0] slew_q, slew_d;
  logic signed [XW-1:0]         diff, mag, step_x, slew_x, cur_x;

  always_comb begin
    cur_x  = XW'(slew_q);
    diff   = XW'(reference_i) - cur_x;
    mag    = (diff < 0) ? -diff : diff;
    step_x = $signed(XW'(step_max_i));
    if (mag > step_x) begin
      slew_x = (diff > 0) ? cur_x + step_x : cur_x - step_x;
    end else begin
      slew_x = XW'(reference_i);
    end
    // the slewed value lies between old value and reference, so it fits
    slew_d = DATA_WIDTH'(slew_x);
    err_o  = EW'(slew_d) - EW'(measured_i);
    lref_o = slew_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slew_q <= '0;
    end else if (step_en_i) begin
      slew_q <= slew_d;
    end
  end

endmodule

// ----- rtl/pirl_integ.sv -----
// term clamps, anti-windup integral state and drive sum
`timescale 1ns / 1ps

module pirl_integ import pirl_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 upd_en_i,
  input  logic signed [DATA_WIDTH+GAIN_W+1:0]  prop_prod_i,
  input  logic signed [DATA_WIDTH+GAIN_W+1:0]  int_prod_i,
  input  logic        [LIM_W-1:0]              limit_i,
  output logic signed [DATA_WIDTH-1:0]         drive_o
);

  localparam int PW = DATA_WIDTH + GAIN_W + 2;
  localparam int CW = PW + 1;

  logic signed [INT_W-1:0] integ_q, integ_d;
  logic signed [CW-1:0]    prop_sh, int_sh, lim_x, prop_c, pmag, dyn, sum, integ_c, drive_x;

  always_comb begin
    prop_sh = CW'(prop_prod_i >>> FRAC_BITS);
    int_sh  = CW'(int_prod_i >>> FRAC_BITS);
    lim_x   = $signed(CW'(limit_i));

    prop_c = prop_sh;
    if (prop_sh > lim_x) begin
      prop_c = lim_x;
    end else if (prop_sh < -lim_x) begin
      prop_c = -lim_x;
    end

    // headroom left for the integral once the proportional term is in
    pmag = (prop_c < 0) ? -prop_c : prop_c;
    dyn  = lim_x - pmag;

    sum     = CW'(integ_q) + int_sh;
    integ_c = sum;
    if (sum > dyn) begin
      integ_c = dyn;
    end else if (sum < -dyn) begin
      integ_c = -dyn;
    end

    integ_d = INT_W'(integ_c);
    drive_x = integ_c + prop_c;
    drive_o = DATA_WIDTH'(drive_x);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
    end else if (upd_en_i) begin
      integ_q <= integ_d;
    end
  end

endmodule

// ----- rtl/pirl_checker.sv -----
// port-level checker for the pi controller, bound to the top level
`timescale 1ns / 1ps
`include "pi_controller_rate_limited_reference_top_defines.svh"

module pirl_checker import pirl_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_ready_i,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input logic [DATA_WIDTH-1:0] drive_i,
  input logic [DATA_WIDTH-1:0] lref_i,
  input logic                  psel,
  input logic                  penable,
  input logic                  pwrite,
  input logic [APB_AW-1:0]     paddr,
  input logic [APB_DW-1:0]     pwdata,
  input logic [APB_DW-1:0]     prdata
);

  localparam logic [APB_DW-1:0] GAIN_MASK = {{(APB_DW-GAIN_W){1'b0}}, {GAIN_W{1'b1}}};
  localparam logic [APB_DW-1:0] LIM_MASK  = {{(APB_DW-LIM_W){1'b0}}, {LIM_W{1'b1}}};

  reg_idx_e          idx;
  logic [APB_DW-1:0] wr_mask, wr_val;
  logic              wr_en, rd_same, stall;

  assign idx     = reg_idx_e'(paddr[APB_AW-1:2]);
  assign wr_mask = (idx == REG_OUT_LIMIT || idx == REG_STEP_MAX) ? LIM_MASK : GAIN_MASK;
  assign wr_val  = pwdata & wr_mask;
  assign wr_en   = psel && penable && pwrite;
  assign rd_same = psel && !pwrite;
  assign stall   = out_valid_i && !out_ready_i;

  `PIRL_ASSERT_NXT(a_out_hold, stall, out_valid_i, "result item dropped")
  `PIRL_ASSERT_NXT(a_out_stable, stall, $stable(drive_i) && $stable(lref_i), "stalled result moved")
  `PIRL_ASSERT_IMP(a_ready_pass, out_ready_i, in_ready_i, "input stalled with output free")
  `PIRL_ASSERT_NXT(a_readback, wr_en,
                   !rd_same || paddr != $past(paddr) || prdata == $past(wr_val),
                   "register readback mismatch")

endmodule

bind pi_controller_rate_limited_reference_top pirl_checker #(
  .DATA_WIDTH (DATA_WIDTH)
) u_pirl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .drive_i     (out_o.drive),
  .lref_i      (out_o.limited_reference),
  .psel        (psel),
  .penable     (penable),
  .pwrite      (pwrite),
  .paddr       (paddr),
  .pwdata      (pwdata),
  .prdata      (prdata)
);
